// ===== hw/rtl/gsp_pkg.sv =====
// Package for the gain-scheduled PID block: payload structs, field widths,
// register indexes and the request/response bundles of the serial units.
// No dependencies.
package gsp_pkg;

  localparam int PV_W       = 16;
  localparam int IDX_W      = 8;
  localparam int GAIN_W     = 32;
  localparam int DRIVE_W    = 32;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int DERR_W     = 30;
  localparam int Q_W        = 13;
  localparam int SKIP_W     = 8;
  localparam int SK10_W     = 12;
  localparam int LIM_W      = 31;
  localparam int GSU_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_STEPS  = 16;
  localparam int DIV_STEPS  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_KC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_KD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_KI    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SETS      = 3'd5;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [PV_W-1:0]          process_value;
    logic [IDX_W-1:0]         gain_index;
    logic signed [GAIN_W-1:0] load_kc;
    logic signed [GAIN_W-1:0] load_kd;
    logic signed [GAIN_W-1:0] load_ki;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      skipped;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [GAIN_W-1:0] quantity;
    logic [GAIN_W-1:0] gain;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] term;
    logic [GAIN_W-1:0] raw;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [Q_W-1:0]    dividend;
    logic [SKIP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/gsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/gsp_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on gsp_pkg.
module gsp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gsp_pkg::div_req_t req,
  output gsp_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(gsp_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(gsp_pkg::DIV_STEPS - 1);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                         state_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [gsp_pkg::Q_W-1:0]         quo_r;
  logic [gsp_pkg::SKIP_W-1:0]      rem_r;
  logic [gsp_pkg::SKIP_W-1:0]      d_r;
  logic [gsp_pkg::SKIP_W:0]        trial;
  logic [gsp_pkg::SKIP_W:0]        rem_nxt;
  logic                            ge;

  always_comb begin
    trial   = {rem_r, quo_r[gsp_pkg::Q_W-1]};
    ge      = (trial >= {1'b0, d_r});
    rem_nxt = ge ? (trial - {1'b0, d_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (req.start) begin
            quo_r   <= req.dividend;
            d_r     <= req.divisor;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= rem_nxt[gsp_pkg::SKIP_W-1:0];
          quo_r <= {quo_r[gsp_pkg::Q_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.busy     = (state_r != D_IDLE);
  assign rsp.quotient = quo_r;

endmodule

// ===== hw/rtl/gsp_mul.sv =====
// Serial sign-magnitude multiplier, two multiplier bits per cycle.
// Returns the product scaled by 2^-16 (toward zero) and the unscaled low word.
// Depends on gsp_pkg.
module gsp_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  gsp_pkg::mul_req_t req,
  output gsp_pkg::mul_rsp_t rsp
);

  localparam int W     = gsp_pkg::GAIN_W;
  localparam int CNT_W = $clog2(gsp_pkg::MUL_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(gsp_pkg::MUL_STEPS - 1);

  typedef enum logic [1:0] {M_IDLE, M_TRIPLE, M_RUN} mstate_t;

  mstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [W-1:0]     m_r;
  logic [W+1:0]     m3_r;
  logic [W+1:0]     h_r;
  logic [W-1:0]     l_r;
  logic [W+1:0]     addend;
  logic [W+2:0]     sum;
  logic [2*W+2:0]   cat;
  logic [W-1:0]     scaled;

  always_comb begin
    case (l_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, m_r};
      2'd2:    addend = {1'b0, m_r, 1'b0};
      default: addend = m3_r;
    endcase
    sum    = {1'b0, h_r} + {1'b0, addend};
    cat    = {sum, l_r};
    scaled = {h_r[15:0], l_r[W-1:16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        M_IDLE: begin
          if (req.start) begin
            m_r     <= req.gain[W-1] ? (~req.gain + 1'b1) : req.gain;
            l_r     <= req.quantity[W-1] ? (~req.quantity + 1'b1) : req.quantity;
            neg_r   <= req.gain[W-1] ^ req.quantity[W-1];
            h_r     <= '0;
            state_r <= M_TRIPLE;
          end
        end
        M_TRIPLE: begin
          m3_r    <= {2'b00, m_r} + {1'b0, m_r, 1'b0};
          cnt_r   <= '0;
          state_r <= M_RUN;
        end
        M_RUN: begin
          h_r   <= {1'b0, cat[2*W+2:W+2]};
          l_r   <= cat[W+1:2];
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= M_IDLE;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != M_IDLE);
  assign rsp.term = neg_r ? (~scaled + 1'b1) : scaled;
  assign rsp.raw  = neg_r ? (~l_r + 1'b1) : l_r;

endmodule

// ===== hw/rtl/gain_scheduled_pid.sv =====
// Top level of the gain-scheduled PID step: config registers, gain table,
// sequencer, the shared serial multiplier and the serial divider.
// Depends on gsp_pkg, gsp_ram, gsp_div, gsp_mul.
//
//   channel  | ports                       | payload
//   ---------+-----------------------------+------------------------------
//   in       | in_valid / in_ready         | in_data  (gsp_pkg::in_t)
//   out      | out_valid / out_ready       | out_data (gsp_pkg::out_t)
//   cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A load item or a skipped tick passes from the idle state through the done state
// to the output register. A computed tick makes four passes through the radix-4
// serial multiplier (derivative scale, then the three gain terms); the divider
// for the integral runs alongside the first pass. One item at a time; the next
// is taken while a result waits in the output register. Synchronous active-low
// reset; cfg_ready is always high.
module gain_scheduled_pid #(
  parameter int GAIN_SETS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  gsp_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output gsp_pkg::out_t                        out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW  = (GAIN_SETS > 1) ? $clog2(GAIN_SETS) : 1;
  localparam int GW  = gsp_pkg::GAIN_W;
  localparam int RW  = 3 * GW;
  localparam logic [gsp_pkg::IDX_W:0] GS_LIM = (gsp_pkg::IDX_W + 1)'(GAIN_SETS);

  localparam logic [1:0] PASS_DSCALE = 2'd0;
  localparam logic [1:0] PASS_PROP   = 2'd1;
  localparam logic [1:0] PASS_DERIV  = 2'd2;
  localparam logic [1:0] PASS_INTEG  = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_MSTART, S_MWAIT, S_DONE} state_t;

  state_t                              state_r;
  logic [1:0]                          pass_r;
  logic                                out_valid_r;
  gsp_pkg::out_t                       out_r;
  logic [GW-1:0]                       res_drive_r;
  logic                                res_skip_r;

  logic [gsp_pkg::PV_W-1:0]            sp_r;
  logic [gsp_pkg::LIM_W-1:0]           lim_r;
  logic [GW-1:0]                       ovr_kc_r;
  logic [GW-1:0]                       ovr_kd_r;
  logic [GW-1:0]                       ovr_ki_r;
  logic [gsp_pkg::GSU_W-1:0]           gsu_r;

  logic [GW-1:0]                       int_acc_r;
  logic [gsp_pkg::ERR_W-1:0]           last_err_r;
  logic [gsp_pkg::SKIP_W-1:0]          skip_r;

  logic [gsp_pkg::ERR_W-1:0]           err_r;
  logic [gsp_pkg::DERR_W-1:0]          derr_r;
  logic [GW-1:0]                       kc_r;
  logic [GW-1:0]                       kd_r;
  logic [GW-1:0]                       ki_r;
  logic [GW-1:0]                       sum_r;

  logic                                in_xfer;
  logic                                idx_in_table;
  logic                                idx_usable;
  logic                                tick_skip;
  logic [gsp_pkg::ERR_W-1:0]           err_nxt;
  logic                                ovr_any;
  logic [RW-1:0]                       ram_rdata;
  logic [RW-1:0]                       ram_wdata;
  logic                                ram_we;
  logic                                ram_re;

  logic [gsp_pkg::PV_W-1:0]            err_mag;
  logic [gsp_pkg::PV_W+4:0]            err_x25;
  logic [gsp_pkg::DIFF_W-1:0]          diff;
  logic [gsp_pkg::SK10_W-1:0]          skip10;
  logic [gsp_pkg::Q_W:0]               int_delta;
  logic [GW:0]                         acc_sum;
  logic [GW:0]                         lim_pos;
  logic [GW:0]                         lim_neg;
  logic [GW-1:0]                       acc_nxt;

  gsp_pkg::mul_req_t                   mul_req;
  gsp_pkg::mul_rsp_t                   mul_rsp;
  gsp_pkg::div_req_t                   div_req;
  gsp_pkg::div_rsp_t                   div_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    idx_in_table = ({1'b0, in_data.gain_index} < GS_LIM);
    idx_usable   = idx_in_table &&
                   ({{(gsp_pkg::IDX_W - gsp_pkg::GSU_W){1'b0}}, gsu_r} > in_data.gain_index);
    tick_skip    = (in_data.process_value == '0) || !idx_usable;
    err_nxt      = {1'b0, sp_r} - {1'b0, in_data.process_value};
    ovr_any      = (ovr_kc_r != '0) || (ovr_kd_r != '0) || (ovr_ki_r != '0);
    ram_we       = in_xfer && (in_data.kind == gsp_pkg::KIND_LOAD) && idx_in_table;
    ram_re       = in_xfer && (in_data.kind == gsp_pkg::KIND_TICK);
    ram_wdata    = {in_data.load_kc, in_data.load_kd, in_data.load_ki};
  end

  gsp_ram #(
    .WIDTH (RW),
    .DEPTH (GAIN_SETS)
  ) u_gain_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.gain_index[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_data.gain_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    err_mag   = err_r[gsp_pkg::ERR_W-1] ? gsp_pkg::PV_W'(~err_r + 1'b1)
                                        : err_r[gsp_pkg::PV_W-1:0];
    err_x25   = {1'b0, err_mag, 4'b0} + {2'b0, err_mag, 3'b0} + {5'b0, err_mag};
    diff      = {err_r[gsp_pkg::ERR_W-1], err_r} -
                {last_err_r[gsp_pkg::ERR_W-1], last_err_r};
    skip10    = {1'b0, skip_r, 3'b0} + {3'b0, skip_r, 1'b0};

    int_delta = err_r[gsp_pkg::ERR_W-1] ? (~{1'b0, div_rsp.quotient} + 1'b1)
                                        : {1'b0, div_rsp.quotient};
    acc_sum   = {int_acc_r[GW-1], int_acc_r} +
                {{(GW - gsp_pkg::Q_W){int_delta[gsp_pkg::Q_W]}}, int_delta};
    lim_pos   = {2'b00, lim_r};
    lim_neg   = ~lim_pos + 1'b1;
    if ($signed(acc_sum) > $signed(lim_pos)) begin
      acc_nxt = lim_pos[GW-1:0];
    end else if ($signed(acc_sum) < $signed(lim_neg)) begin
      acc_nxt = lim_neg[GW-1:0];
    end else begin
      acc_nxt = acc_sum[GW-1:0];
    end
  end

  always_comb begin
    mul_req.start = (state_r == S_MSTART);
    case (pass_r)
      PASS_DSCALE: begin
        mul_req.quantity = {{(GW - gsp_pkg::DIFF_W){diff[gsp_pkg::DIFF_W-1]}}, diff};
        mul_req.gain     = {{(GW - gsp_pkg::SK10_W){1'b0}}, skip10};
      end
      PASS_PROP: begin
        mul_req.quantity = {{(GW - gsp_pkg::ERR_W){err_r[gsp_pkg::ERR_W-1]}}, err_r};
        mul_req.gain     = kc_r;
      end
      PASS_DERIV: begin
        mul_req.quantity = {{(GW - gsp_pkg::DERR_W){derr_r[gsp_pkg::DERR_W-1]}}, derr_r};
        mul_req.gain     = kd_r;
      end
      default: begin
        mul_req.quantity = int_acc_r;
        mul_req.gain     = ki_r;
      end
    endcase
    div_req.start    = (state_r == S_MSTART) && (pass_r == PASS_DSCALE);
    div_req.dividend = err_x25[gsp_pkg::PV_W+4:8];
    div_req.divisor  = skip_r;
  end

  gsp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  gsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= PASS_DSCALE;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      lim_r       <= '0;
      ovr_kc_r    <= '0;
      ovr_kd_r    <= '0;
      ovr_ki_r    <= '0;
      gsu_r       <= '0;
      int_acc_r   <= '0;
      last_err_r  <= '0;
      skip_r      <= gsp_pkg::SKIP_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gsp_pkg::CFG_TARGET:         sp_r     <= cfg_data[gsp_pkg::PV_W-1:0];
          gsp_pkg::CFG_INTEGRAL_LIMIT: lim_r    <= cfg_data[gsp_pkg::LIM_W-1:0];
          gsp_pkg::CFG_OVERRIDE_KC:    ovr_kc_r <= cfg_data;
          gsp_pkg::CFG_OVERRIDE_KD:    ovr_kd_r <= cfg_data;
          gsp_pkg::CFG_OVERRIDE_KI:    ovr_ki_r <= cfg_data;
          gsp_pkg::CFG_GAIN_SETS:      gsu_r    <= cfg_data[gsp_pkg::GSU_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            res_drive_r <= '0;
            res_skip_r  <= 1'b1;
            pass_r      <= PASS_DSCALE;
            err_r       <= err_nxt;
            if (in_data.kind == gsp_pkg::KIND_LOAD) begin
              state_r <= S_DONE;
            end else if (tick_skip) begin
              if (skip_r != {gsp_pkg::SKIP_W{1'b1}}) begin
                skip_r <= skip_r + 1'b1;
              end
              state_r <= S_DONE;
            end else begin
              state_r <= S_MSTART;
            end
          end
        end
        S_MSTART: begin
          if (pass_r == PASS_DSCALE) begin
            kc_r <= ovr_any ? ovr_kc_r : ram_rdata[RW-1:2*GW];
            kd_r <= ovr_any ? ovr_kd_r : ram_rdata[2*GW-1:GW];
            ki_r <= ovr_any ? ovr_ki_r : ram_rdata[GW-1:0];
          end
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (!mul_rsp.busy && !div_rsp.busy) begin
            case (pass_r)
              PASS_DSCALE: begin
                derr_r     <= mul_rsp.raw[gsp_pkg::DERR_W-1:0];
                int_acc_r  <= acc_nxt;
                last_err_r <= err_r;
                skip_r     <= gsp_pkg::SKIP_W'(1);
                pass_r     <= PASS_PROP;
                state_r    <= S_MSTART;
              end
              PASS_PROP: begin
                sum_r   <= mul_rsp.term;
                pass_r  <= PASS_DERIV;
                state_r <= S_MSTART;
              end
              PASS_DERIV: begin
                sum_r   <= sum_r + mul_rsp.term;
                pass_r  <= PASS_INTEG;
                state_r <= S_MSTART;
              end
              default: begin
                res_drive_r <= sum_r + mul_rsp.term;
                res_skip_r  <= 1'b0;
                state_r     <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r.drive   <= res_drive_r;
      out_r.skipped <= res_skip_r;
    end
  end

endmodule

// ===== hw/rtl/gsp_checker.sv =====
// Port-level checks for the gain-scheduled PID block, bound to the top level.
// Depends on gsp_pkg and gain_scheduled_pid.
module gsp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input gsp_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.skipped |-> out_data.drive == '0)
    else $error("skipped result carries nonzero drive");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gain_scheduled_pid gsp_checker u_gsp_checker (.*);
